/* rtl/core/dnd_pkg.sv */
package dnd_pkg;

    localparam int MSG_BYTES    = 512;
    localparam int MSG_AW       = 9;
    localparam int POS_W        = MSG_AW + 1;
    localparam int MAX_HOPS     = 16;
    localparam int MAX_NAME     = 255;
    localparam int CONSUMED_MAX = 256;
    localparam int TXT_BANKS    = 4;
    localparam int TXT_ROWS     = 64;
    localparam int TXT_RW       = 6;

    localparam logic [7:0] PTR_MIN   = 8'd192;
    localparam logic [7:0] LABEL_MAX = 8'd63;
    localparam logic [7:0] DOT_CHAR  = 8'h2E;

    localparam logic FUNC_STORE  = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef struct packed {
        logic              is_decode;
        logic [MSG_AW-1:0] addr;
        logic [7:0]        data;
    } t_cmd;

    typedef struct packed {
        logic [31:0] name_chars;
        logic [2:0]  char_count;
        logic        last;
        logic [8:0]  consumed;
        logic        error;
    } t_result;

endpackage

/* rtl/core/dnd_ram.sv */
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dnd_front.sv */
module dnd_front
    import dnd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [MSG_AW-1:0] i_addr,
    input  logic [7:0]        i_data,
    output logic              o_q_valid,
    output t_cmd              o_q_cmd,
    input  logic              i_q_pop
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_cmd       cmd_in;

    always_comb begin
        cmd_in.is_decode = (i_func == FUNC_DECODE);
        cmd_in.addr      = i_addr;
        cmd_in.data      = i_data;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && (r_cnt != 2'd0);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");

    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) && !pop |=> r_cnt == 2'd2)
        else $error("full queue lost an entry");

endmodule

/* rtl/core/dnd_back.sv */
module dnd_back
    import dnd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_LEN     = 8'b0000_0010,
        S_PTR     = 8'b0000_0100,
        S_LABEL   = 8'b0000_1000,
        S_DOT     = 8'b0001_0000,
        S_EMIT_RD = 8'b0010_0000,
        S_EMIT    = 8'b0100_0000,
        S_ERR     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [MSG_AW-1:0] r_start, n_start;
    logic              r_ptaken, n_ptaken;
    logic [4:0]        r_hops, n_hops;
    logic [5:0]        r_rem, n_rem;
    logic [7:0]        r_len, n_len;
    logic [8:0]        r_consumed, n_consumed;
    logic [5:0]        r_hi, n_hi;
    logic [7:0]        r_left, n_left;
    logic [TXT_RW-1:0] r_row, n_row;

    logic              r_out_valid;
    t_result           r_out, out_next;
    logic              out_load, out_free;

    // message store port
    logic              m_we, m_re;
    logic [MSG_AW-1:0] m_raddr;
    logic [7:0]        m_rdata;

    // name text, banked so one row gives four characters
    logic              t_we, t_re;
    logic [7:0]        t_wbyte;
    logic [TXT_RW-1:0] t_rrow;
    logic [7:0]        t_rdata [TXT_BANKS];

    logic [POS_W-1:0]  pos_inc;
    logic              pos_inc_ok;
    logic [POS_W-1:0]  cons_zero, cons_ptr;
    logic [9:0]        len_sum;
    logic [13:0]       ptr_target;
    logic [5:0]        hops_inc;
    logic [2:0]        emit_cnt;
    logic              emit_last;
    logic [31:0]       emit_word;

    assign m_we = (r_state == S_IDLE) && i_q_valid && !i_q_cmd.is_decode
               && ({1'b0, i_q_cmd.addr} < POS_W'(MSG_BYTES));

    dnd_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (i_q_cmd.addr),
        .i_wdata (i_q_cmd.data),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    for (genvar g = 0; g < TXT_BANKS; g++) begin : g_txt
        dnd_ram #(.WIDTH(8), .DEPTH(TXT_ROWS)) u_txt_ram (
            .i_clk   (i_clk),
            .i_we    (t_we && (r_len[1:0] == 2'(g))),
            .i_waddr (r_len[7:2]),
            .i_wdata (t_wbyte),
            .i_re    (t_re),
            .i_raddr (t_rrow),
            .o_rdata (t_rdata[g])
        );
    end

    assign pos_inc    = r_pos + POS_W'(1);
    assign pos_inc_ok = pos_inc < POS_W'(MSG_BYTES);
    assign cons_zero  = r_pos - {1'b0, r_start} + POS_W'(1);
    assign cons_ptr   = r_pos - {1'b0, r_start} + POS_W'(2);
    assign len_sum    = {2'b0, r_len} + {2'b0, m_rdata} + 10'd1;
    assign ptr_target = {r_hi, m_rdata};
    assign hops_inc   = {1'b0, r_hops} + 6'd1;
    assign out_free   = !r_out_valid || i_ready;

    assign emit_last = (r_left <= 8'd4);
    assign emit_cnt  = emit_last ? r_left[2:0] : 3'd4;

    always_comb begin
        for (int i = 0; i < TXT_BANKS; i++) begin
            emit_word[8*i +: 8] = (3'(i) < emit_cnt) ? t_rdata[i] : 8'd0;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_start    = r_start;
        n_ptaken   = r_ptaken;
        n_hops     = r_hops;
        n_rem      = r_rem;
        n_len      = r_len;
        n_consumed = r_consumed;
        n_hi       = r_hi;
        n_left     = r_left;
        n_row      = r_row;
        o_q_pop    = 1'b0;
        m_re       = 1'b0;
        m_raddr    = pos_inc[MSG_AW-1:0];
        t_we       = 1'b0;
        t_wbyte    = m_rdata;
        t_re       = 1'b0;
        t_rrow     = r_row;
        out_load   = 1'b0;
        out_next   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.is_decode) begin
                        // a 9-bit start offset is always inside the store
                        n_pos      = {1'b0, i_q_cmd.addr};
                        n_start    = i_q_cmd.addr;
                        n_ptaken   = 1'b0;
                        n_hops     = '0;
                        n_len      = '0;
                        n_consumed = '0;
                        m_re       = 1'b1;
                        m_raddr    = i_q_cmd.addr;
                        n_state    = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (m_rdata == 8'd0) begin
                    if (!r_ptaken) begin
                        n_consumed = cons_zero[8:0];
                    end
                    if (!r_ptaken && (cons_zero > POS_W'(CONSUMED_MAX))) begin
                        n_state = S_ERR;
                    end else begin
                        n_left  = r_len;
                        n_row   = '0;
                        n_state = S_EMIT_RD;
                    end
                end else if (m_rdata >= PTR_MIN) begin
                    if (!pos_inc_ok) begin
                        n_state = S_ERR;
                    end else begin
                        m_re    = 1'b1;
                        n_hi    = m_rdata[5:0];
                        n_state = S_PTR;
                    end
                end else if (m_rdata > LABEL_MAX) begin
                    n_state = S_ERR;
                end else if (len_sum > 10'(MAX_NAME) || !pos_inc_ok) begin
                    n_state = S_ERR;
                end else begin
                    m_re    = 1'b1;
                    n_pos   = pos_inc;
                    n_rem   = m_rdata[5:0];
                    n_state = S_LABEL;
                end
            end
            S_PTR: begin
                if ((!r_ptaken && (cons_ptr > POS_W'(CONSUMED_MAX)))
                    || (hops_inc > 6'(MAX_HOPS))
                    || (ptr_target >= 14'(MSG_BYTES))) begin
                    n_state = S_ERR;
                end else begin
                    if (!r_ptaken) begin
                        n_consumed = cons_ptr[8:0];
                    end
                    n_ptaken = 1'b1;
                    n_hops   = hops_inc[4:0];
                    n_pos    = ptr_target[POS_W-1:0];
                    m_re     = 1'b1;
                    m_raddr  = ptr_target[MSG_AW-1:0];
                    n_state  = S_LEN;
                end
            end
            S_LABEL: begin
                t_we  = 1'b1;
                n_len = r_len + 8'd1;
                n_rem = r_rem - 6'd1;
                if (r_rem == 6'd1) begin
                    n_state = S_DOT;
                end else if (!pos_inc_ok) begin
                    n_state = S_ERR;
                end else begin
                    m_re  = 1'b1;
                    n_pos = pos_inc;
                end
            end
            S_DOT: begin
                t_we    = 1'b1;
                t_wbyte = DOT_CHAR;
                n_len   = r_len + 8'd1;
                if (!pos_inc_ok) begin
                    n_state = S_ERR;
                end else begin
                    m_re    = 1'b1;
                    n_pos   = pos_inc;
                    n_state = S_LEN;
                end
            end
            S_EMIT_RD: begin
                t_re    = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_next.name_chars = emit_word;
                    out_next.char_count = emit_cnt;
                    out_next.last       = emit_last;
                    out_next.consumed   = emit_last ? r_consumed : 9'd0;
                    out_next.error      = 1'b0;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // prefetch the next row while this one goes out
                        n_left = r_left - 8'd4;
                        n_row  = r_row + TXT_RW'(1);
                        t_re   = 1'b1;
                        t_rrow = r_row + TXT_RW'(1);
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_next.last  = 1'b1;
                    out_next.error = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_start    <= n_start;
        r_ptaken   <= n_ptaken;
        r_hops     <= n_hops;
        r_rem      <= n_rem;
        r_len      <= n_len;
        r_consumed <= n_consumed;
        r_hi       <= n_hi;
        r_left     <= n_left;
        r_row      <= n_row;
        if (out_load) begin
            r_out <= out_next;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.error |->
            r_out.last && (r_out.char_count == 3'd0) && (r_out.consumed == 9'd0))
        else $error("error result not a bare last beat");

    a_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last |->
            (r_out.char_count == 3'd4) && (r_out.consumed == 9'd0))
        else $error("non-final beat not full");

    a_store_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_we |-> (r_state == S_IDLE) && o_q_pop)
        else $error("store written outside idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !r_out_valid || i_ready)
        else $error("output overwritten while held");

endmodule

/* rtl/core/dns_name_decompress.sv */
// Stores are accepted back to back while the walker is idle; a store passes through the
// two-entry input queue and is written to the message RAM from there. A decode gives
// at least one result beat, and one result beat per cycle once emission starts, as long
// as the output is accepted. The walk is bound by the single read port of the message
// RAM, one byte per cycle.
// Reset (i_rst_n low, synchronous) clears the queue, the walker and the output stage;
// the message RAM is not cleared and holds garbage until written.
module dns_name_decompress
    import dnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // address[8:0], byte_value[16:9], zero pad
    input  logic        i_s_axis_tuser,  // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // name_chars[31:0], char_count[34:32],
                                         // consumed[43:35], zero pad
    output logic        o_m_axis_tlast,  // last
    output logic        o_m_axis_tuser   // error
);

    logic    q_valid, q_pop;
    t_cmd    q_cmd;
    t_result result;

    dnd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_func    (i_s_axis_tuser),
        .i_addr    (i_s_axis_tdata[8:0]),
        .i_data    (i_s_axis_tdata[16:9]),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    dnd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    assign o_m_axis_tdata = {4'b0, result.consumed, result.char_count, result.name_chars};
    assign o_m_axis_tlast = result.last;
    assign o_m_axis_tuser = result.error;

endmodule
